// ===== rtl/core/imuseq_pkg.sv =====
// imuseq_pkg: shared types, codes and the built-in register table of the
// inertial sensor init sequencer. No dependencies.
package imuseq_pkg;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_DELAY = 2'd2;
   localparam logic [1:0] KIND_DONE  = 2'd3;

   localparam logic [2:0] STATUS_OK     = 3'd0;
   localparam logic [2:0] STATUS_AXIS   = 3'd1;
   localparam logic [2:0] STATUS_BUS    = 3'd2;
   localparam logic [2:0] STATUS_ID     = 3'd3;
   localparam logic [2:0] STATUS_VERIFY = 3'd4;

   localparam logic DEV_ACCEL = 1'b0;
   localparam logic DEV_GYRO  = 1'b1;

   localparam logic [7:0] CHIP_ID_REG     = 8'h00;
   localparam logic [7:0] ACCEL_RESET_REG = 8'h7E;
   localparam logic [7:0] GYRO_RESET_REG  = 8'h14;
   localparam logic [7:0] SOFT_RESET_CMD  = 8'hB6;
   localparam logic [7:0] ACCEL_CHIP_ID   = 8'h1E;
   localparam logic [7:0] GYRO_CHIP_ID    = 8'h0F;

   localparam logic [5:0] WAIT_POWER_MS   = 6'd1;
   localparam logic [5:0] WAIT_ACCEL_MS   = 6'd50;
   localparam logic [5:0] WAIT_GYRO_MS    = 6'd30;

   localparam logic [3:0] TABLE_LEN = 4'd11;

   localparam logic       CSR_AXIS_SOURCES   = 1'b0;
   localparam logic       CSR_AXIS_NEGATIONS = 1'b1;
   localparam logic [5:0] AXIS_SOURCES_RESET = 6'd36;

   typedef struct packed {
      logic       dev;
      logic [7:0] reg_addr;
      logic [7:0] value;
      logic [2:0] settle;
   } row_type;

   typedef struct packed {
      logic [1:0] request_kind;
      logic       device_select;
      logic [7:0] register_address;
      logic [7:0] write_value;
      logic [5:0] wait_ms;
      logic [2:0] status;
      logic [7:0] acc_id;
      logic [7:0] gyro_id;
   } rsp_type;

   function automatic row_type table_row_at(input logic [3:0] idx);
      row_type r;
      case (idx)
         4'd0:    r = '{DEV_ACCEL, 8'h7C, 8'h00, 3'd5};
         4'd1:    r = '{DEV_ACCEL, 8'h7D, 8'h04, 3'd5};
         4'd2:    r = '{DEV_ACCEL, 8'h40, 8'hAB, 3'd0};
         4'd3:    r = '{DEV_ACCEL, 8'h41, 8'h01, 3'd0};
         4'd4:    r = '{DEV_ACCEL, 8'h53, 8'h08, 3'd0};
         4'd5:    r = '{DEV_ACCEL, 8'h58, 8'h04, 3'd0};
         4'd6:    r = '{DEV_GYRO,  8'h0F, 8'h00, 3'd0};
         4'd7:    r = '{DEV_GYRO,  8'h10, 8'h02, 3'd0};
         4'd8:    r = '{DEV_GYRO,  8'h15, 8'h80, 3'd0};
         4'd9:    r = '{DEV_GYRO,  8'h16, 8'h00, 3'd0};
         4'd10:   r = '{DEV_GYRO,  8'h18, 8'h01, 3'd0};
         default: r = '{DEV_ACCEL, 8'h7C, 8'h00, 3'd5};
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/imuseq_if.sv =====
// imuseq_if: valid/ready channel interfaces for request beats and result beats.
// Depends on nothing.
interface imuseq_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic       bus_ok;
   logic [7:0] read_data;

   modport source (output valid, operation, bus_ok, read_data, input ready);
   modport sink (input valid, operation, bus_ok, read_data, output ready);
endinterface

interface imuseq_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] request_kind;
   logic       device_select;
   logic [7:0] register_address;
   logic [7:0] write_value;
   logic [5:0] wait_ms;
   logic [2:0] status;
   logic [7:0] acc_id;
   logic [7:0] gyro_id;

   modport source (output valid, request_kind, device_select, register_address,
                   write_value, wait_ms, status, acc_id, gyro_id, input ready);
   modport sink (input valid, request_kind, device_select, register_address,
                 write_value, wait_ms, status, acc_id, gyro_id, output ready);
endinterface

// ===== rtl/core/imu_init_write_verify_sequencer.sv =====
// Init sequencer for a two-die inertial sensor.
// Channels: req carries start beats (operation 0) and bus/delay responses
// (operation 1); rsp carries one request per beat, or the final report
// (request_kind done, with status and both chip ids). A response while idle
// gives no rsp beat. csr_* writes axis_sources (index 0) and axis_negations
// (index 1); write only while the block is idle.
// Path: a req beat is captured in the input register, then the state machine
// and table lookup run combinationally into the rsp register, which holds its
// rsp beat; the step into the rsp register waits while rsp is held off.
// Throughput: one req beat per cycle while rsp is not held off; the input
// register and the rsp register let a new beat in while a result waits.
// Stall: if rsp is held off, one beat waits in the input register and req
// ready drops until rsp drains.
// Reset: synchronous, active high; clears both registers' valid flags, the
// sequence state and the ids, and loads axis_sources 36, axis_negations 0.
module imu_init_write_verify_sequencer import imuseq_pkg::*; #(
   parameter int RETRY_LIMIT = 3
) (
   input  logic        clock,
   input  logic        reset,
   imuseq_req_if.sink  req,
   imuseq_rsp_if.source rsp,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [5:0]  csr_write_data
);
   logic       in_valid_ff, in_valid_in;
   logic       in_operation_ff;
   logic       in_bus_ok_ff;
   logic [7:0] in_read_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;
   logic [5:0] axis_sources_ff;
   logic [2:0] axis_negations_ff;

   logic       accept;
   logic       fire;
   logic       axis_ok;
   logic       emit;
   rsp_type    result;

   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || fire;
   assign accept    = req.valid && req.ready;

   assign in_valid_in  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (fire && emit) ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   imuseq_axis_check u_axis (
      .axis_sources   (axis_sources_ff),
      .axis_negations (axis_negations_ff),
      .axis_ok        (axis_ok)
   );

   imuseq_ctrl #(.RETRY_LIMIT(RETRY_LIMIT)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .operation (in_operation_ff),
      .bus_ok    (in_bus_ok_ff),
      .read_data (in_read_data_ff),
      .axis_ok   (axis_ok),
      .emit      (emit),
      .rsp       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         axis_sources_ff   <= AXIS_SOURCES_RESET;
         axis_negations_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            if (csr_index == CSR_AXIS_NEGATIONS) begin
               axis_negations_ff <= csr_write_data[2:0];
            end else begin
               axis_sources_ff <= csr_write_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_operation_ff <= req.operation;
         in_bus_ok_ff    <= req.bus_ok;
         in_read_data_ff <= req.read_data;
      end
      if (fire && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.request_kind     = rsp_ff.request_kind;
   assign rsp.device_select    = rsp_ff.device_select;
   assign rsp.register_address = rsp_ff.register_address;
   assign rsp.write_value      = rsp_ff.write_value;
   assign rsp.wait_ms          = rsp_ff.wait_ms;
   assign rsp.status           = rsp_ff.status;
   assign rsp.acc_id           = rsp_ff.acc_id;
   assign rsp.gyro_id          = rsp_ff.gyro_id;
endmodule

// ===== rtl/core/imuseq_axis_check.sv =====
// imuseq_axis_check: checks that the axis map is a right-handed signed
// permutation. Pure combinational logic, no dependencies.
module imuseq_axis_check (
   input  logic [5:0] axis_sources,
   input  logic [2:0] axis_negations,
   output logic       axis_ok
);
   logic [1:0] src0, src1, src2;
   logic       perm_ok;
   logic       inv_parity;
   logic       neg_parity;

   assign src0 = axis_sources[1:0];
   assign src1 = axis_sources[3:2];
   assign src2 = axis_sources[5:4];

   assign perm_ok = (src0 != 2'd3) && (src1 != 2'd3) && (src2 != 2'd3)
                    && (src0 != src1) && (src0 != src2) && (src1 != src2);
   assign inv_parity = (src0 > src1) ^ (src0 > src2) ^ (src1 > src2);
   assign neg_parity = ^axis_negations;
   assign axis_ok    = perm_ok && (inv_parity == neg_parity);
endmodule

// ===== rtl/core/imuseq_ctrl.sv =====
// imuseq_ctrl: sequence state machine; turns one registered beat into the next
// request or the final report. Depends on imuseq_pkg.
module imuseq_ctrl import imuseq_pkg::*; #(
   parameter int RETRY_LIMIT = 3
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic       operation,
   input  logic       bus_ok,
   input  logic [7:0] read_data,
   input  logic       axis_ok,
   output logic       emit,
   output rsp_type    rsp
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_DUMMY, ST_WAIT1, ST_RST_A, ST_WAIT_A, ST_RST_G, ST_WAIT_G,
      ST_ID_A, ST_ID_G, ST_T_WR, ST_T_WAIT, ST_T_RD
   } step_type;

   localparam logic [2:0] LIMIT = 3'(RETRY_LIMIT);

   step_type   step_ff, step_in;
   logic [1:0] attempt_ff, attempt_in;
   logic [3:0] index_ff, index_in;
   logic       mismatch_ff, mismatch_in;
   logic [7:0] acc_id_ff, acc_id_in;
   logic [7:0] gyro_id_ff, gyro_id_in;

   logic       fin;
   logic [2:0] fin_status;
   logic       fail;
   logic [2:0] fail_status;
   step_type   fail_restart;
   logic [3:0] index_cur;
   logic [3:0] index_next;
   logic [2:0] attempt_sum;
   logic [1:0] attempt_wrap;
   row_type    row;

   function automatic rsp_type issue_req(input step_type s, input row_type r);
      rsp_type q;
      q = '0;
      unique case (s)
         ST_DUMMY, ST_ID_A: begin
            q.request_kind     = KIND_READ;
            q.register_address = CHIP_ID_REG;
         end
         ST_ID_G: begin
            q.request_kind     = KIND_READ;
            q.device_select    = DEV_GYRO;
            q.register_address = CHIP_ID_REG;
         end
         ST_WAIT1: begin
            q.request_kind = KIND_DELAY;
            q.wait_ms      = WAIT_POWER_MS;
         end
         ST_RST_A: begin
            q.request_kind     = KIND_WRITE;
            q.register_address = ACCEL_RESET_REG;
            q.write_value      = SOFT_RESET_CMD;
         end
         ST_WAIT_A: begin
            q.request_kind = KIND_DELAY;
            q.wait_ms      = WAIT_ACCEL_MS;
         end
         ST_RST_G: begin
            q.request_kind     = KIND_WRITE;
            q.device_select    = DEV_GYRO;
            q.register_address = GYRO_RESET_REG;
            q.write_value      = SOFT_RESET_CMD;
         end
         ST_WAIT_G: begin
            q.request_kind = KIND_DELAY;
            q.wait_ms      = WAIT_GYRO_MS;
         end
         ST_T_WR: begin
            q.request_kind     = KIND_WRITE;
            q.device_select    = r.dev;
            q.register_address = r.reg_addr;
            q.write_value      = r.value;
         end
         ST_T_WAIT: begin
            q.request_kind = KIND_DELAY;
            q.wait_ms      = {3'd0, r.settle};
         end
         ST_T_RD: begin
            q.request_kind     = KIND_READ;
            q.device_select    = r.dev;
            q.register_address = r.reg_addr;
         end
         default: begin
            q.request_kind = KIND_DONE;
            q.status       = STATUS_BUS;
         end
      endcase
      return q;
   endfunction

   always_comb begin
      step_in      = step_ff;
      attempt_in   = attempt_ff;
      index_in     = index_ff;
      mismatch_in  = mismatch_ff;
      acc_id_in    = acc_id_ff;
      gyro_id_in   = gyro_id_ff;
      emit         = 1'b1;
      fin          = 1'b0;
      fin_status   = STATUS_OK;
      fail         = 1'b0;
      fail_status  = STATUS_BUS;
      fail_restart = step_ff;
      index_cur    = (index_ff >= TABLE_LEN) ? 4'd0 : index_ff;
      index_next   = index_cur + 4'd1;
      row          = table_row_at(index_cur);
      attempt_sum  = {1'b0, attempt_ff} + 3'd1;
      attempt_wrap = attempt_sum[1:0];

      if (!operation) begin
         acc_id_in   = '0;
         gyro_id_in  = '0;
         index_in    = '0;
         mismatch_in = 1'b0;
         if (!axis_ok) begin
            fin        = 1'b1;
            fin_status = STATUS_AXIS;
         end else begin
            step_in    = ST_DUMMY;
            attempt_in = '0;
         end
      end else begin
         index_in = index_cur;
         unique case (step_ff)
            ST_DUMMY, ST_RST_A, ST_RST_G, ST_ID_A: begin
               if (!bus_ok) begin
                  fail = 1'b1;
               end else begin
                  attempt_in = '0;
                  if (step_ff == ST_ID_A) begin
                     acc_id_in = read_data;
                  end
                  step_in = step_type'(step_ff + 4'd1);
               end
            end
            ST_WAIT1, ST_WAIT_A, ST_WAIT_G: begin
               attempt_in = '0;
               step_in    = step_type'(step_ff + 4'd1);
            end
            ST_ID_G: begin
               if (!bus_ok) begin
                  if (attempt_sum >= LIMIT) begin
                     acc_id_in = '0;
                  end
                  fail = 1'b1;
               end else begin
                  gyro_id_in = read_data;
                  if (acc_id_ff != ACCEL_CHIP_ID || read_data != GYRO_CHIP_ID) begin
                     fin        = 1'b1;
                     fin_status = STATUS_ID;
                  end else begin
                     index_in    = '0;
                     mismatch_in = 1'b0;
                     attempt_in  = '0;
                     step_in     = ST_T_WR;
                  end
               end
            end
            ST_T_WR: begin
               if (!bus_ok) begin
                  fail        = 1'b1;
                  fail_status = mismatch_ff ? STATUS_VERIFY : STATUS_BUS;
               end else begin
                  step_in = (row.settle != 3'd0) ? ST_T_WAIT : ST_T_RD;
               end
            end
            ST_T_WAIT: begin
               step_in = ST_T_RD;
            end
            ST_T_RD: begin
               if (bus_ok && read_data == row.value) begin
                  index_in    = index_next;
                  mismatch_in = 1'b0;
                  if (index_next >= TABLE_LEN) begin
                     fin        = 1'b1;
                     fin_status = STATUS_OK;
                  end else begin
                     attempt_in = '0;
                     step_in    = ST_T_WR;
                  end
               end else begin
                  if (bus_ok) begin
                     mismatch_in = 1'b1;
                  end
                  fail         = 1'b1;
                  fail_status  = (bus_ok || mismatch_ff) ? STATUS_VERIFY : STATUS_BUS;
                  fail_restart = ST_T_WR;
               end
            end
            default: begin
               step_in = ST_IDLE;
               emit    = 1'b0;
            end
         endcase
      end

      if (fail) begin
         attempt_in = attempt_wrap;
         if (attempt_wrap == 2'd0 || {1'b0, attempt_wrap} >= LIMIT) begin
            fin        = 1'b1;
            fin_status = fail_status;
         end else begin
            step_in = fail_restart;
         end
      end

      if (fin) begin
         step_in     = ST_IDLE;
         attempt_in  = '0;
         index_in    = '0;
         mismatch_in = 1'b0;
         rsp              = '0;
         rsp.request_kind = KIND_DONE;
         rsp.status       = fin_status;
         rsp.acc_id       = acc_id_in;
         rsp.gyro_id      = gyro_id_in;
      end else begin
         rsp = issue_req(step_in, table_row_at(index_in));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= ST_IDLE;
         attempt_ff  <= '0;
         index_ff    <= '0;
         mismatch_ff <= 1'b0;
         acc_id_ff   <= '0;
         gyro_id_ff  <= '0;
      end else if (fire) begin
         step_ff     <= step_in;
         attempt_ff  <= attempt_in;
         index_ff    <= index_in;
         mismatch_ff <= mismatch_in;
         acc_id_ff   <= acc_id_in;
         gyro_id_ff  <= gyro_id_in;
      end
   end
endmodule

// ===== rtl/core/imuseq_checker.sv =====
// imuseq_checker: port-level assertions for the init sequencer, bound to the
// top level. Depends on imuseq_pkg and imuseq_if.
module imuseq_checker import imuseq_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_request_kind,
   input logic       rsp_device_select,
   input logic [7:0] rsp_register_address,
   input logic [5:0] rsp_wait_ms,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_acc_id,
   input logic [7:0] rsp_gyro_id
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_req_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req held off without rsp stall");

   a_request_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_request_kind != KIND_DONE |->
         rsp_status == STATUS_OK && rsp_acc_id == 8'd0 && rsp_gyro_id == 8'd0)
      else $error("request beat carries report fields");

   a_delay_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_request_kind == KIND_DELAY |->
         !rsp_device_select && rsp_register_address == 8'd0
         && rsp_wait_ms != 6'd0 && rsp_wait_ms <= WAIT_ACCEL_MS)
      else $error("malformed delay beat");

   a_reset_clear: assert property (@(posedge clock)
      reset && req_valid |=> !rsp_valid && req_ready)
      else $error("state not cleared by reset");
endmodule

bind imu_init_write_verify_sequencer imuseq_checker u_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req.valid),
   .req_ready            (req.ready),
   .rsp_valid            (rsp.valid),
   .rsp_ready            (rsp.ready),
   .rsp_request_kind     (rsp.request_kind),
   .rsp_device_select    (rsp.device_select),
   .rsp_register_address (rsp.register_address),
   .rsp_wait_ms          (rsp.wait_ms),
   .rsp_status           (rsp.status),
   .rsp_acc_id           (rsp.acc_id),
   .rsp_gyro_id          (rsp.gyro_id)
);

// ===== test/imu_init_write_verify_sequencer_test.sv =====
`timescale 1ns / 1ps
// Testbench for the inertial sensor init sequencer: drives start and response beats, predicts
// each request or final report, and checks every result beat field by field.
// Depends on imuseq_pkg, the imuseq channel interfaces and the sequencer RTL.
module imu_init_write_verify_sequencer_test;
   import imuseq_pkg::*;

   localparam int RETRY_LIMIT = 3;
   localparam int PHASES = 9;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic OP_START = 1'b0;
   localparam logic OP_RESPONSE = 1'b1;

   typedef enum logic [4:0] {
      SEQ_IDLE, SEQ_DUMMY_READ, SEQ_POWER_WAIT, SEQ_ACCEL_RESET, SEQ_ACCEL_WAIT,
      SEQ_GYRO_RESET, SEQ_GYRO_WAIT, SEQ_ACCEL_ID, SEQ_GYRO_ID, SEQ_ROW_WRITE,
      SEQ_ROW_SETTLE, SEQ_ROW_READBACK
   } seq_step_type;

   typedef enum logic [1:0] {BY_PREDICTOR, NO_BEAT, TYPED_BEAT} check_type;

   typedef struct packed {
      logic       operation;
      logic       bus_ok;
      logic [7:0] read_data;
      check_type  how;
      rsp_type    want;
   } directed_row_type;

   localparam row_type SETUP_ROWS [TABLE_LEN] = '{
      '{DEV_ACCEL, 8'h7C, 8'h00, 3'd5}, '{DEV_ACCEL, 8'h7D, 8'h04, 3'd5},
      '{DEV_ACCEL, 8'h40, 8'hAB, 3'd0}, '{DEV_ACCEL, 8'h41, 8'h01, 3'd0},
      '{DEV_ACCEL, 8'h53, 8'h08, 3'd0}, '{DEV_ACCEL, 8'h58, 8'h04, 3'd0},
      '{DEV_GYRO, 8'h0F, 8'h00, 3'd0}, '{DEV_GYRO, 8'h10, 8'h02, 3'd0},
      '{DEV_GYRO, 8'h15, 8'h80, 3'd0}, '{DEV_GYRO, 8'h16, 8'h00, 3'd0},
      '{DEV_GYRO, 8'h18, 8'h01, 3'd0}
   };

   localparam logic [5:0] AXIS_PERMS [6] = '{6'd36, 6'd24, 6'd33, 6'd9, 6'd18, 6'd6};
   localparam logic [5:0] FIXED_SOURCES [5] = '{6'd63, 6'd0, 6'd33, 6'd36, 6'd18};
   localparam logic [2:0] FIXED_NEGATIONS [5] = '{3'd7, 3'd0, 3'd1, 3'd7, 3'd6};

   localparam rsp_type WANT_CHIP_ID_READ =
      '{KIND_READ, DEV_ACCEL, CHIP_ID_REG, 8'h00, 6'd0, STATUS_OK, 8'h00, 8'h00};
   localparam rsp_type WANT_POWER_WAIT =
      '{KIND_DELAY, 1'b0, 8'h00, 8'h00, WAIT_POWER_MS, STATUS_OK, 8'h00, 8'h00};
   localparam rsp_type WANT_ACCEL_RESET =
      '{KIND_WRITE, DEV_ACCEL, ACCEL_RESET_REG, SOFT_RESET_CMD, 6'd0, STATUS_OK, 8'h00, 8'h00};
   localparam rsp_type WANT_VERIFY_DONE =
      '{KIND_DONE, 1'b0, 8'h00, 8'h00, 6'd0, STATUS_VERIFY, ACCEL_CHIP_ID, GYRO_CHIP_ID};
   localparam rsp_type WANT_BUS_DONE =
      '{KIND_DONE, 1'b0, 8'h00, 8'h00, 6'd0, STATUS_BUS, 8'h00, 8'h00};

   localparam directed_row_type DIRECTED [24] = '{
      '{OP_RESPONSE, 1'b1, 8'hFF, NO_BEAT, '0},
      '{OP_START, 1'b1, 8'h00, TYPED_BEAT, WANT_CHIP_ID_READ},
      '{OP_RESPONSE, 1'b0, 8'h00, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b1, 8'h5A, TYPED_BEAT, WANT_POWER_WAIT},
      '{OP_RESPONSE, 1'b0, 8'hA5, TYPED_BEAT, WANT_ACCEL_RESET},
      '{OP_RESPONSE, 1'b1, 8'h00, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b1, 8'h00, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b1, 8'h00, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b1, 8'h00, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b1, ACCEL_CHIP_ID, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b1, GYRO_CHIP_ID, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b1, 8'h00, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b1, 8'h00, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b1, 8'hFF, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b1, 8'h00, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b1, 8'h00, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b0, 8'h00, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b0, 8'h00, TYPED_BEAT, WANT_VERIFY_DONE},
      '{OP_START, 1'b1, 8'h00, BY_PREDICTOR, '0},
      '{OP_START, 1'b0, 8'hFF, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b0, 8'hFF, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b0, 8'h00, BY_PREDICTOR, '0},
      '{OP_RESPONSE, 1'b0, 8'hFF, TYPED_BEAT, WANT_BUS_DONE},
      '{OP_RESPONSE, 1'b1, 8'h00, NO_BEAT, '0}
   };

   logic clock;
   logic reset;
   logic csr_write_en;
   logic csr_index;
   logic [5:0] csr_write_data;

   imuseq_req_if req_ch ();
   imuseq_rsp_if rsp_ch ();

   imu_init_write_verify_sequencer #(.RETRY_LIMIT(RETRY_LIMIT)) uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   logic [5:0]   axis_src;
   logic [2:0]   axis_neg;
   seq_step_type seq_step;
   logic [1:0]   attempts;
   logic [3:0]   row_idx;
   logic         readback_bad;
   logic [7:0]   acc_id_got;
   logic [7:0]   gyro_id_got;

   rsp_type awaited_requests [$];
   int finishes [5];
   int errors;
   int beats_checked;
   int items_sent;
   int cycles;
   bit gaps_on;
   bit stalls_on;

   function automatic bit axis_map_valid();
      logic [1:0] src [3];
      logic [2:0] seen;
      int swaps;
      seen = '0;
      swaps = 0;
      for (int i = 0; i < 3; i++) begin
         src[i] = axis_src[2*i +: 2];
         if (src[i] == 2'd3 || seen[src[i]]) begin
            return 1'b0;
         end
         seen[src[i]] = 1'b1;
         for (int j = 0; j < i; j++) begin
            if (src[j] > src[i]) swaps++;
         end
      end
      return (swaps[0] ^ (^axis_neg)) == 1'b0;
   endfunction

   function automatic rsp_type close_sequence(logic [2:0] status);
      rsp_type beat;
      beat = '{KIND_DONE, 1'b0, 8'h00, 8'h00, 6'd0, status, acc_id_got, gyro_id_got};
      seq_step = SEQ_IDLE;
      attempts = '0;
      row_idx = '0;
      readback_bad = 1'b0;
      finishes[status]++;
      return beat;
   endfunction

   function automatic rsp_type current_request();
      row_type r;
      r = SETUP_ROWS[(row_idx < TABLE_LEN) ? row_idx : 4'd0];
      case (seq_step)
         SEQ_DUMMY_READ, SEQ_ACCEL_ID:
            return '{KIND_READ, DEV_ACCEL, CHIP_ID_REG, 8'h00, 6'd0, STATUS_OK, 8'h00, 8'h00};
         SEQ_POWER_WAIT:
            return '{KIND_DELAY, 1'b0, 8'h00, 8'h00, WAIT_POWER_MS, STATUS_OK, 8'h00, 8'h00};
         SEQ_ACCEL_RESET:
            return '{KIND_WRITE, DEV_ACCEL, ACCEL_RESET_REG, SOFT_RESET_CMD, 6'd0, STATUS_OK,
                     8'h00, 8'h00};
         SEQ_ACCEL_WAIT:
            return '{KIND_DELAY, 1'b0, 8'h00, 8'h00, WAIT_ACCEL_MS, STATUS_OK, 8'h00, 8'h00};
         SEQ_GYRO_RESET:
            return '{KIND_WRITE, DEV_GYRO, GYRO_RESET_REG, SOFT_RESET_CMD, 6'd0, STATUS_OK,
                     8'h00, 8'h00};
         SEQ_GYRO_WAIT:
            return '{KIND_DELAY, 1'b0, 8'h00, 8'h00, WAIT_GYRO_MS, STATUS_OK, 8'h00, 8'h00};
         SEQ_GYRO_ID:
            return '{KIND_READ, DEV_GYRO, CHIP_ID_REG, 8'h00, 6'd0, STATUS_OK, 8'h00, 8'h00};
         SEQ_ROW_WRITE:
            return '{KIND_WRITE, r.dev, r.reg_addr, r.value, 6'd0, STATUS_OK, 8'h00, 8'h00};
         SEQ_ROW_SETTLE:
            return '{KIND_DELAY, 1'b0, 8'h00, 8'h00, {3'b000, r.settle}, STATUS_OK,
                     8'h00, 8'h00};
         SEQ_ROW_READBACK:
            return '{KIND_READ, r.dev, r.reg_addr, 8'h00, 6'd0, STATUS_OK, 8'h00, 8'h00};
         default:
            return close_sequence(STATUS_BUS);
      endcase
   endfunction

   function automatic rsp_type enter_step(seq_step_type nxt);
      seq_step = nxt;
      attempts = '0;
      return current_request();
   endfunction

   function automatic rsp_type retry_or_close(logic [2:0] status, seq_step_type restart);
      attempts = attempts + 2'd1;
      if (attempts >= RETRY_LIMIT || attempts == 2'd0) begin
         return close_sequence(status);
      end
      seq_step = restart;
      return current_request();
   endfunction

   function automatic bit sequencer_advance(input logic op, input logic ok,
                                            input logic [7:0] data, output rsp_type beat);
      row_type r;
      beat = '0;
      if (op == OP_START) begin
         acc_id_got = '0;
         gyro_id_got = '0;
         row_idx = '0;
         readback_bad = 1'b0;
         if (axis_map_valid()) beat = enter_step(SEQ_DUMMY_READ);
         else beat = close_sequence(STATUS_AXIS);
         return 1'b1;
      end
      if (row_idx >= TABLE_LEN) row_idx = '0;
      r = SETUP_ROWS[row_idx];
      case (seq_step)
         SEQ_DUMMY_READ: begin
            if (ok) beat = enter_step(SEQ_POWER_WAIT);
            else beat = retry_or_close(STATUS_BUS, SEQ_DUMMY_READ);
         end
         SEQ_POWER_WAIT: beat = enter_step(SEQ_ACCEL_RESET);
         SEQ_ACCEL_RESET: begin
            if (ok) beat = enter_step(SEQ_ACCEL_WAIT);
            else beat = retry_or_close(STATUS_BUS, SEQ_ACCEL_RESET);
         end
         SEQ_ACCEL_WAIT: beat = enter_step(SEQ_GYRO_RESET);
         SEQ_GYRO_RESET: begin
            if (ok) beat = enter_step(SEQ_GYRO_WAIT);
            else beat = retry_or_close(STATUS_BUS, SEQ_GYRO_RESET);
         end
         SEQ_GYRO_WAIT: beat = enter_step(SEQ_ACCEL_ID);
         SEQ_ACCEL_ID: begin
            if (!ok) begin
               beat = retry_or_close(STATUS_BUS, SEQ_ACCEL_ID);
            end else begin
               acc_id_got = data;
               beat = enter_step(SEQ_GYRO_ID);
            end
         end
         SEQ_GYRO_ID: begin
            if (!ok) begin
               if (int'(attempts) + 1 >= RETRY_LIMIT) acc_id_got = '0;
               beat = retry_or_close(STATUS_BUS, SEQ_GYRO_ID);
            end else begin
               gyro_id_got = data;
               if (acc_id_got != ACCEL_CHIP_ID || gyro_id_got != GYRO_CHIP_ID) begin
                  beat = close_sequence(STATUS_ID);
               end else begin
                  row_idx = '0;
                  readback_bad = 1'b0;
                  beat = enter_step(SEQ_ROW_WRITE);
               end
            end
         end
         SEQ_ROW_WRITE: begin
            if (!ok) begin
               beat = retry_or_close(readback_bad ? STATUS_VERIFY : STATUS_BUS, SEQ_ROW_WRITE);
            end else begin
               seq_step = (r.settle != 3'd0) ? SEQ_ROW_SETTLE : SEQ_ROW_READBACK;
               beat = current_request();
            end
         end
         SEQ_ROW_SETTLE: begin
            seq_step = SEQ_ROW_READBACK;
            beat = current_request();
         end
         SEQ_ROW_READBACK: begin
            if (ok && data == r.value) begin
               row_idx = row_idx + 4'd1;
               readback_bad = 1'b0;
               if (row_idx >= TABLE_LEN) beat = close_sequence(STATUS_OK);
               else beat = enter_step(SEQ_ROW_WRITE);
            end else begin
               if (ok) readback_bad = 1'b1;
               beat = retry_or_close(readback_bad ? STATUS_VERIFY : STATUS_BUS, SEQ_ROW_WRITE);
            end
         end
         default: begin
            seq_step = SEQ_IDLE;
            return 1'b0;
         end
      endcase
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      if (errors < 100) $display("mismatch on result beat %0d: %s", beats_checked, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
   endtask

   // Drive one beat after a random gap, hold it until accepted, then advance the predictor.
   task automatic send_beat(input logic op, input logic ok, input logic [7:0] data,
                            output bit produced, output rsp_type beat);
      int gap;
      int pick;
      gap = 0;
      if (gaps_on) begin
         pick = $urandom_range(19);
         if (pick == 19) gap = $urandom_range(12, 40);
         else if (pick >= 12) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.bus_ok <= ok;
      req_ch.read_data <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      produced = sequencer_advance(op, ok, data, beat);
   endtask

   // Drop valid, wait for all predicted beats, then leave room for an ignored beat in flight.
   task automatic wind_down();
      req_ch.valid <= 1'b0;
      while (awaited_requests.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_axis_map(input logic [5:0] src, input logic [2:0] neg);
      csr_write_en <= 1'b1;
      csr_index <= CSR_AXIS_SOURCES;
      csr_write_data <= src;
      @(posedge clock);
      csr_index <= CSR_AXIS_NEGATIONS;
      csr_write_data <= {3'b000, neg};
      @(posedge clock);
      csr_write_en <= 1'b0;
      axis_src = src;
      axis_neg = neg;
   endtask

   initial begin
      clock = 1'b0;
   end

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still awaited", cycles,
                  awaited_requests.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      int run;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!stalls_on || $urandom_range(3) != 0) begin
            rsp_ch.ready <= 1'b1;
            run = $urandom_range(1, 12);
         end else begin
            rsp_ch.ready <= 1'b0;
            run = ($urandom_range(15) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
         end
         repeat (run - 1) @(posedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type got_beat;
      rsp_type want_beat;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got_beat = '{rsp_ch.request_kind, rsp_ch.device_select, rsp_ch.register_address,
                      rsp_ch.write_value, rsp_ch.wait_ms, rsp_ch.status, rsp_ch.acc_id,
                      rsp_ch.gyro_id};
         if (awaited_requests.size() == 0) begin
            report_mismatch("result beat with nothing awaited");
         end else begin
            want_beat = awaited_requests.pop_front();
            check_field("request_kind", 8'(got_beat.request_kind),
                        8'(want_beat.request_kind));
            check_field("device_select", 8'(got_beat.device_select),
                        8'(want_beat.device_select));
            check_field("register_address", got_beat.register_address,
                        want_beat.register_address);
            check_field("write_value", got_beat.write_value, want_beat.write_value);
            check_field("wait_ms", 8'(got_beat.wait_ms), 8'(want_beat.wait_ms));
            check_field("status", 8'(got_beat.status), 8'(want_beat.status));
            check_field("acc_id", got_beat.acc_id, want_beat.acc_id);
            check_field("gyro_id", got_beat.gyro_id, want_beat.gyro_id);
         end
         beats_checked++;
      end
   end

   initial begin
      directed_row_type row;
      rsp_type beat;
      bit produced;
      logic op;
      logic ok;
      logic [7:0] data;
      logic [5:0] src;
      logic [2:0] neg;
      int budget;
      int counted;

      errors = 0;
      beats_checked = 0;
      items_sent = 0;
      cycles = 0;
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      foreach (finishes[i]) finishes[i] = 0;
      axis_src = AXIS_SOURCES_RESET;
      axis_neg = '0;
      seq_step = SEQ_IDLE;
      attempts = '0;
      row_idx = '0;
      readback_bad = 1'b0;
      acc_id_got = '0;
      gyro_id_got = '0;

      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.operation <= OP_START;
      req_ch.bus_ok <= 1'b0;
      req_ch.read_data <= '0;
      csr_write_en <= 1'b0;
      csr_index <= CSR_AXIS_SOURCES;
      csr_write_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         send_beat(row.operation, row.bus_ok, row.read_data, produced, beat);
         if (row.how == TYPED_BEAT) awaited_requests.push_back(row.want);
         else if (row.how == BY_PREDICTOR && produced) awaited_requests.push_back(beat);
      end
      wind_down();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 5) begin
            src = FIXED_SOURCES[ph];
            neg = FIXED_NEGATIONS[ph];
         end else begin
            src = AXIS_PERMS[$urandom_range(5)];
            neg = 3'($urandom_range(7));
            axis_src = src;
            axis_neg = neg;
            if (!axis_map_valid() && $urandom_range(3) != 0) neg = neg ^ 3'b001;
         end
         write_axis_map(src, neg);
         gaps_on = (ph % 4) != 2;
         stalls_on = (ph % 4) != 2;
         budget = axis_map_valid() ? 170 : 40;
         counted = 0;
         while (counted < budget) begin
            ok = $urandom_range(12) != 0;
            data = 8'($urandom_range(255));
            if (seq_step == SEQ_IDLE) begin
               op = ($urandom_range(9) == 0) ? OP_RESPONSE : OP_START;
            end else begin
               op = ($urandom_range(40) == 0) ? OP_START : OP_RESPONSE;
               if ($urandom_range(19) < 17) begin
                  if (seq_step == SEQ_ACCEL_ID) data = ACCEL_CHIP_ID;
                  else if (seq_step == SEQ_GYRO_ID) data = GYRO_CHIP_ID;
                  else if (seq_step == SEQ_ROW_READBACK) data = SETUP_ROWS[row_idx].value;
               end
            end
            send_beat(op, ok, data, produced, beat);
            if (produced) begin
               awaited_requests.push_back(beat);
               counted++;
            end
         end
         // fail every access so the sequence ends before the map changes
         while (seq_step != SEQ_IDLE) begin
            send_beat(OP_RESPONSE, 1'b0, 8'($urandom_range(255)), produced, beat);
            if (produced) awaited_requests.push_back(beat);
         end
         wind_down();
      end

      $display("checked %0d result beats from %0d accepted beats over %0d axis map settings",
               beats_checked, items_sent, PHASES + 1);
      $display("sequences ended ok %0d, axis map %0d, bus %0d, chip id %0d, verify %0d",
               finishes[STATUS_OK], finishes[STATUS_AXIS], finishes[STATUS_BUS],
               finishes[STATUS_ID], finishes[STATUS_VERIFY]);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
